### src/rsu_pkg.sv
`timescale 1ns / 1ps

package rsu_pkg;

  // Field widths fixed by the item format.
  localparam int FUNC_W   = 3;
  localparam int LETTER_W = 5;
  localparam int ROT_W    = 3;
  localparam int CFG_W    = 4;

  // Defaults for the top-level parameters.
  localparam int MAX_ROTORS_DEF    = 8;
  localparam int ALPHABET_SIZE_DEF = 26;

  // Item function codes; the two unused codes fall to the default arm.
  typedef enum logic [FUNC_W-1:0] {
    FN_STEP  = 3'd0,
    FN_FWD   = 3'd1,
    FN_BWD   = 3'd2,
    FN_WIRE  = 3'd3,
    FN_POS   = 3'd4,
    FN_NOTCH = 3'd5
  } func_code_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_STEP,
    S_FWD_RD,
    S_FWD_WB,
    S_BWD_SETUP,
    S_BWD_SCAN,
    S_DONE
  } state_t;

endpackage

### src/rsu_in_if.sv
`timescale 1ns / 1ps

interface rsu_in_if
  import rsu_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [LETTER_W-1:0] letter;
  logic [ROT_W-1:0]    rotor_index;
  logic [LETTER_W-1:0] entry_index;
  logic [LETTER_W-1:0] entry_value;
  logic [LETTER_W-1:0] new_position;
  logic                notch_flag;

  modport source (
    output valid, func, letter, rotor_index, entry_index, entry_value,
           new_position, notch_flag,
    input  ready
  );
  modport sink (
    input  valid, func, letter, rotor_index, entry_index, entry_value,
           new_position, notch_flag,
    output ready
  );
endinterface

### src/rsu_out_if.sv
`timescale 1ns / 1ps

interface rsu_out_if
  import rsu_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [LETTER_W-1:0] letter_out;
  logic                mapping_missing;

  modport source (
    output valid, letter_out, mapping_missing,
    input  ready
  );
  modport sink (
    input  valid, letter_out, mapping_missing,
    output ready
  );
endinterface

### src/rsu_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port with registered data.
module rsu_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 208,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

### src/rotor_stack_substitution.sv
`timescale 1ns / 1ps

// Rotor stack substitution engine. Each input beat carries one item (step,
// forward pass, backward pass, or a load of wiring, position or notch) and
// yields exactly one result beat. Items are handled one at a time by a small
// sequencer around a modular adder, modular subtract logic and a wiring RAM
// with one read port; the input is not ready while an item is in work. A
// step advances the first active rotor and carries on to the next while the
// rotor lands on a notch; a forward pass does one RAM read and one modular
// update per rotor; a backward pass runs a one-entry-per-cycle inverse search
// through each rotor's wiring, from the last active rotor down, and is
// shorter when the search hits early or fails. With no rotors in use a pass
// or a step goes straight to the result. The input is ready again in the
// same cycle the result is offered; both wait while the previous result
// still waits to be taken. Wiring entries hold garbage until written;
// positions and notch masks clear on reset. The rotor count register may
// only be written while no item is in work.
module rotor_stack_substitution
  import rsu_pkg::*;
#(
  parameter int MAX_ROTORS    = MAX_ROTORS_DEF,
  parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  rsu_in_if.sink           in_bus,
  rsu_out_if.source        out_bus,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int LW    = LETTER_W;
  localparam int CW    = $clog2(MAX_ROTORS + 1);
  localparam int RIW   = (MAX_ROTORS > 1) ? $clog2(MAX_ROTORS) : 1;
  localparam int DEPTH = MAX_ROTORS * ALPHABET_SIZE;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Residue table for 5-bit values; built at elaboration.
  logic [LW-1:0] mod_lut [2**LW];
  for (genvar g = 0; g < 2**LW; g++) begin : g_mod
    assign mod_lut[g] = LW'(g % ALPHABET_SIZE);
  end

  // Subtract modulo the alphabet for operands already in range.
  function automatic logic [LW-1:0] mod_sub(input logic [LW-1:0] a,
                                            input logic [LW-1:0] p);
    logic [LW:0] t;
    if (a >= p) begin
      t = {1'b0, a} - {1'b0, p};
    end else begin
      t = {1'b0, a} + (LW+1)'(ALPHABET_SIZE) - {1'b0, p};
    end
    return t[LW-1:0];
  endfunction

  state_t state_r, state_nxt;

  // Captured item fields.
  logic [FUNC_W-1:0]   func_r, func_nxt;
  logic [LW-1:0]       letter_r, letter_nxt;
  logic [ROT_W-1:0]    rot_in_r, rot_in_nxt;
  logic [LW-1:0]       ent_r, ent_nxt;
  logic [LW-1:0]       val_r, val_nxt;
  logic [LW-1:0]       npos_r, npos_nxt;
  logic                nflag_r, nflag_nxt;

  // Sequencer working registers.
  logic [CW-1:0]       rot_r, rot_nxt;
  logic [LW-1:0]       d_r, d_nxt;
  logic [LW-1:0]       tgt_r, tgt_nxt;
  logic [LW-1:0]       ic_r, ic_nxt;
  logic                issue_r, issue_nxt;
  logic                chk_vld_r, chk_vld_nxt;
  logic [LW-1:0]       chk_idx_r, chk_idx_nxt;
  logic                miss_r, miss_nxt;

  // Rotor state and configuration.
  logic [LW-1:0]            pos_r [MAX_ROTORS];
  logic [LW-1:0]            pos_nxt [MAX_ROTORS];
  logic [ALPHABET_SIZE-1:0] notch_r [MAX_ROTORS];
  logic [ALPHABET_SIZE-1:0] notch_nxt [MAX_ROTORS];
  logic [CFG_W-1:0]         cfg_r, cfg_nxt;

  // Result register.
  logic                out_valid_r, out_valid_nxt;
  logic [LW-1:0]       out_letter_r, out_letter_nxt;
  logic                out_miss_r, out_miss_nxt;

  // RAM port signals.
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [AW-1:0]       ram_raddr;
  logic [LW-1:0]       ram_rdata;

  // Shared datapath terms.
  logic [CW-1:0]       n_act;
  logic [RIW-1:0]      rot_idx;
  logic [LW-1:0]       pos_cur;
  logic [LW:0]         sum_w;
  logic [LW-1:0]       sum_mod;
  logic [LW-1:0]       step_pos;
  logic [AW-1:0]       base_addr;
  logic                last_rot;
  logic                in_acc;
  logic                out_free;
  logic                load_ok;
  logic                entry_ok;

  assign in_acc   = in_bus.valid && in_bus.ready;
  assign out_free = !out_valid_r || out_bus.ready;

  // Active rotor count, capped at the stack depth.
  assign n_act = (32'(cfg_r) > MAX_ROTORS) ? CW'(MAX_ROTORS) : CW'(cfg_r);

  assign rot_idx   = rot_r[RIW-1:0];
  assign pos_cur   = pos_r[rot_idx];
  assign base_addr = AW'(32'(rot_idx) * ALPHABET_SIZE);
  assign last_rot  = (rot_r + CW'(1)) >= n_act;

  // Modular add of letter and rotor position.
  assign sum_w   = {1'b0, d_r} + {1'b0, pos_cur};
  assign sum_mod = (sum_w >= (LW+1)'(ALPHABET_SIZE)) ?
                   LW'(sum_w - (LW+1)'(ALPHABET_SIZE)) : LW'(sum_w);
  assign step_pos = (pos_cur == LW'(ALPHABET_SIZE - 1)) ? '0 : pos_cur + LW'(1);

  assign load_ok  = 32'(rot_in_r) < MAX_ROTORS;
  assign entry_ok = 32'(ent_r) < ALPHABET_SIZE;

  // Wiring write happens in the dispatch cycle of a wiring load.
  assign ram_we    = (state_r == S_EXEC) && (func_r == FN_WIRE) && load_ok && entry_ok;
  assign ram_waddr = AW'(32'(rot_in_r) * ALPHABET_SIZE) + AW'(ent_r);
  assign ram_raddr = (state_r == S_BWD_SCAN) ? base_addr + AW'(ic_r)
                                             : base_addr + AW'(sum_mod);

  rsu_ram #(
    .WIDTH (LW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (val_r),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        case (func_r)
          FN_STEP: state_nxt = (n_act == '0) ? S_DONE : S_STEP;
          FN_FWD:  state_nxt = (n_act == '0) ? S_DONE : S_FWD_RD;
          FN_BWD:  state_nxt = (n_act == '0) ? S_DONE : S_BWD_SETUP;
          default: state_nxt = S_DONE;
        endcase
      end
      S_STEP: begin
        if (!notch_r[rot_idx][step_pos] || last_rot) state_nxt = S_DONE;
      end
      S_FWD_RD: state_nxt = S_FWD_WB;
      S_FWD_WB: state_nxt = last_rot ? S_DONE : S_FWD_RD;
      S_BWD_SETUP: state_nxt = S_BWD_SCAN;
      S_BWD_SCAN: begin
        if (chk_vld_r && ram_rdata == tgt_r) begin
          state_nxt = (rot_r == '0) ? S_DONE : S_BWD_SETUP;
        end else if (chk_vld_r && chk_idx_r == LW'(ALPHABET_SIZE - 1)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and output logic.
  always_comb begin
    func_nxt    = func_r;
    letter_nxt  = letter_r;
    rot_in_nxt  = rot_in_r;
    ent_nxt     = ent_r;
    val_nxt     = val_r;
    npos_nxt    = npos_r;
    nflag_nxt   = nflag_r;
    rot_nxt     = rot_r;
    d_nxt       = d_r;
    tgt_nxt     = tgt_r;
    ic_nxt      = ic_r;
    issue_nxt   = issue_r;
    chk_vld_nxt = chk_vld_r;
    chk_idx_nxt = chk_idx_r;
    miss_nxt    = miss_r;
    pos_nxt     = pos_r;
    notch_nxt   = notch_r;
    cfg_nxt     = cfg_we ? cfg_wdata : cfg_r;

    out_valid_nxt  = (out_valid_r && out_bus.ready) ? 1'b0 : out_valid_r;
    out_letter_nxt = out_letter_r;
    out_miss_nxt   = out_miss_r;

    case (state_r)
      S_IDLE: begin
        // Capture the item beat; letter and position are reduced on entry.
        if (in_acc) begin
          func_nxt   = in_bus.func;
          letter_nxt = mod_lut[in_bus.letter];
          rot_in_nxt = in_bus.rotor_index;
          ent_nxt    = in_bus.entry_index;
          val_nxt    = in_bus.entry_value;
          npos_nxt   = mod_lut[in_bus.new_position];
          nflag_nxt  = in_bus.notch_flag;
        end
      end
      S_EXEC: begin
        miss_nxt = 1'b0;
        d_nxt    = letter_r;
        rot_nxt  = '0;
        case (func_r)
          FN_BWD: begin
            if (n_act != '0) rot_nxt = n_act - CW'(1);
          end
          FN_POS: begin
            if (load_ok) pos_nxt[rot_in_r[RIW-1:0]] = npos_r;
          end
          FN_NOTCH: begin
            if (load_ok && entry_ok) notch_nxt[rot_in_r[RIW-1:0]][ent_r] = nflag_r;
          end
          default: begin
          end
        endcase
      end
      S_STEP: begin
        // Advance this rotor; carry on while it lands on a notch.
        pos_nxt[rot_idx] = step_pos;
        if (notch_r[rot_idx][step_pos] && !last_rot) rot_nxt = rot_r + CW'(1);
      end
      S_FWD_WB: begin
        d_nxt = mod_sub(mod_lut[ram_rdata], pos_cur);
        if (!last_rot) rot_nxt = rot_r + CW'(1);
      end
      S_BWD_SETUP: begin
        tgt_nxt     = sum_mod;
        ic_nxt      = '0;
        issue_nxt   = 1'b1;
        chk_vld_nxt = 1'b0;
      end
      S_BWD_SCAN: begin
        // One contact issued and one compared per cycle.
        chk_vld_nxt = issue_r;
        chk_idx_nxt = ic_r;
        if (issue_r) begin
          ic_nxt = ic_r + LW'(1);
          if (ic_r == LW'(ALPHABET_SIZE - 1)) issue_nxt = 1'b0;
        end
        if (chk_vld_r && ram_rdata == tgt_r) begin
          d_nxt       = mod_sub(chk_idx_r, pos_cur);
          issue_nxt   = 1'b0;
          chk_vld_nxt = 1'b0;
          if (rot_r != '0) rot_nxt = rot_r - CW'(1);
        end else if (chk_vld_r && chk_idx_r == LW'(ALPHABET_SIZE - 1)) begin
          miss_nxt    = 1'b1;
          issue_nxt   = 1'b0;
          chk_vld_nxt = 1'b0;
        end
      end
      S_DONE: begin
        // Hand the result to the output register once it is free.
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_miss_nxt   = miss_r && (func_r == FN_BWD);
          out_letter_nxt = (func_r == FN_FWD || func_r == FN_BWD) ? d_r : '0;
        end
      end
      default: begin
      end
    endcase
  end

  // Registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      issue_r     <= 1'b0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
      cfg_r       <= '0;
      for (int i = 0; i < MAX_ROTORS; i++) begin
        pos_r[i]   <= '0;
        notch_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      issue_r     <= issue_nxt;
      chk_vld_r   <= chk_vld_nxt;
      out_valid_r <= out_valid_nxt;
      cfg_r       <= cfg_nxt;
      pos_r       <= pos_nxt;
      notch_r     <= notch_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r       <= func_nxt;
    letter_r     <= letter_nxt;
    rot_in_r     <= rot_in_nxt;
    ent_r        <= ent_nxt;
    val_r        <= val_nxt;
    npos_r       <= npos_nxt;
    nflag_r      <= nflag_nxt;
    rot_r        <= rot_nxt;
    d_r          <= d_nxt;
    tgt_r        <= tgt_nxt;
    ic_r         <= ic_nxt;
    chk_idx_r    <= chk_idx_nxt;
    miss_r       <= miss_nxt;
    out_letter_r <= out_letter_nxt;
    out_miss_r   <= out_miss_nxt;
  end

  assign in_bus.ready            = (state_r == S_IDLE);
  assign out_bus.valid           = out_valid_r;
  assign out_bus.letter_out      = out_letter_r;
  assign out_bus.mapping_missing = out_miss_r;

endmodule

### src/rsu_checker.sv
`timescale 1ns / 1ps

module rsu_checker
  import rsu_pkg::*;
#(
  parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [LETTER_W-1:0] out_letter,
  input logic                out_missing
);

  // A result beat that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped before it was taken");

  // Once a beat is taken the engine is busy on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input still ready right after an accepted beat");

  // Results are always letters of the alphabet.
  a_letter_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(out_letter) < ALPHABET_SIZE)
    else $error("result letter outside the alphabet");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !out_missing || !out_valid)
    else $error("result offered right after reset");

endmodule

bind rotor_stack_substitution rsu_checker #(
  .ALPHABET_SIZE (ALPHABET_SIZE)
) u_rsu_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_bus.valid),
  .in_ready    (in_bus.ready),
  .out_valid   (out_bus.valid),
  .out_ready   (out_bus.ready),
  .out_letter  (out_bus.letter_out),
  .out_missing (out_bus.mapping_missing)
);
